// File: design/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants of the protobuf field encoder: the command
// that travels from the front end through the queue to the byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

	localparam int unsigned FNUM_W = 32;
	localparam int unsigned WT_W   = 3;
	localparam int unsigned TAG_W  = FNUM_W + WT_W;
	localparam int unsigned VAL_W  = 64;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned GRP_W  = 7;
	localparam int unsigned CNT_W  = 4;

	// Actions of an input item.
	localparam logic [1:0] ACT_FIELD   = 2'd0;
	localparam logic [1:0] ACT_TAG     = 2'd1;
	localparam logic [1:0] ACT_VALUE   = 2'd2;
	localparam logic [1:0] ACT_PAYLOAD = 2'd3;

	// Wire types.
	localparam logic [WT_W-1:0] WT_VARINT  = 3'd0;
	localparam logic [WT_W-1:0] WT_FIXED64 = 3'd1;
	localparam logic [WT_W-1:0] WT_LENGTH  = 3'd2;
	localparam logic [WT_W-1:0] WT_FIXED32 = 3'd5;

	// Byte counts of the little-endian encodings.
	localparam logic [CNT_W-1:0] LE8_BYTES = 4'd8;
	localparam logic [CNT_W-1:0] LE4_BYTES = 4'd4;

	// Status codes.
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	// How the value part of a command is emitted.
	typedef enum logic [2:0] {
		VM_NONE,
		VM_VARINT,
		VM_LE8,
		VM_LE4,
		VM_BYTE,
		VM_ERROR
	} vmode_t;

	// Emitter phase.
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TAG,
		PH_VAL
	} phase_t;

	typedef struct packed {
		logic             has_tag;
		logic [TAG_W-1:0] tag;
		vmode_t           mode;
		logic [VAL_W-1:0] value;
	} pfe_cmd_t;

endpackage

`default_nettype wire

// File: design/pfe_front.sv
// ----------------------------------------------------------------------------
// pfe_front
// Accepts input items, validates the tag, applies zero omission and turns
// each item into an emitter command. Items that give no bytes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_front (
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   action,
	input  wire logic [pfe_pkg::FNUM_W-1:0]   field_num,
	input  wire logic [pfe_pkg::WT_W-1:0]     wtype,
	input  wire logic [pfe_pkg::VAL_W-1:0]    value,
	input  wire logic [pfe_pkg::BYTE_W-1:0]   payload_byte,
	input  wire logic                         q_full,
	output logic                              push,
	output pfe_pkg::pfe_cmd_t                 cmd
);
	import pfe_pkg::*;

	logic             tag_ok;
	logic             val_zero;
	logic             drop;

	assign in_ready = !q_full;

	always_comb begin
		tag_ok = (field_num != '0) &&
			((wtype == WT_VARINT) || (wtype == WT_FIXED64) ||
			 (wtype == WT_LENGTH) || (wtype == WT_FIXED32));
		// Fixed32 looks at the low word only.
		if (wtype == WT_FIXED32) begin
			val_zero = (value[31:0] == '0);
		end else begin
			val_zero = (value == '0);
		end
	end

	always_comb begin
		drop        = 1'b0;
		cmd.has_tag = 1'b0;
		cmd.tag     = {field_num, wtype};
		cmd.mode    = VM_NONE;
		cmd.value   = value;
		case (action)
			ACT_FIELD: begin
				if (val_zero) begin
					drop = 1'b1;
				end else if (!tag_ok) begin
					cmd.mode = VM_ERROR;
				end else begin
					cmd.has_tag = 1'b1;
					case (wtype)
						WT_FIXED64: cmd.mode = VM_LE8;
						WT_FIXED32: cmd.mode = VM_LE4;
						default:    cmd.mode = VM_VARINT;
					endcase
				end
			end
			ACT_TAG: begin
				if (!tag_ok) begin
					cmd.mode = VM_ERROR;
				end else begin
					cmd.has_tag = 1'b1;
				end
			end
			ACT_VALUE: begin
				cmd.mode = VM_VARINT;
			end
			default: begin
				cmd.mode  = VM_BYTE;
				cmd.value = {{(VAL_W-BYTE_W){1'b0}}, payload_byte};
			end
		endcase
	end

	assign push = in_valid && in_ready && !drop;

endmodule

`default_nettype wire

// File: design/pfe_queue.sv
// ----------------------------------------------------------------------------
// pfe_queue
// Small command queue between the front end and the byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  pfe_pkg::pfe_cmd_t      push_data,
	output logic                   full,
	input  wire logic              pop,
	output logic                   pop_valid,
	output pfe_pkg::pfe_cmd_t      pop_data
);
	import pfe_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	pfe_cmd_t               mem_q [DEPTH];
	logic     [PTR_W-1:0]   wr_ptr_q;
	logic     [PTR_W-1:0]   rd_ptr_q;
	logic     [CNT_W-1:0]   count_q;
	logic                   do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if ((push && !full) && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!(push && !full) && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count exceeds depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full && !do_pop |=> $stable(wr_ptr_q))
		else $error("write pointer moved while queue full");

endmodule

`default_nettype wire

// File: design/pfe_back.sv
// ----------------------------------------------------------------------------
// pfe_back
// Byte emitter: serializes one command into wire bytes, one per cycle
// while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cmd_valid,
	input  pfe_pkg::pfe_cmd_t                cmd,
	output logic                             cmd_pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [pfe_pkg::BYTE_W-1:0]       out_byte,
	output logic                             last,
	output logic                             status
);
	import pfe_pkg::*;

	phase_t              phase_q;
	phase_t              phase_d;
	logic [TAG_W-1:0]    tag_q;
	logic [VAL_W-1:0]    val_q;
	vmode_t              mode_q;
	logic [CNT_W-1:0]    cnt_q;

	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                last_q;
	logic                status_q;

	logic                emit;
	logic [BYTE_W-1:0]   em_byte;
	logic                em_status;
	logic                tag_more;
	logic                val_more;
	logic                item_last;

	assign emit     = (phase_q != PH_IDLE) && (!out_valid_q || out_ready);
	assign tag_more = (tag_q[TAG_W-1:GRP_W] != '0);
	assign val_more = (val_q[VAL_W-1:GRP_W] != '0);

	// Byte of the current step and whether it closes the item.
	always_comb begin
		em_byte   = '0;
		em_status = STATUS_OK;
		item_last = 1'b0;
		case (phase_q)
			PH_TAG: begin
				em_byte   = {tag_more, tag_q[GRP_W-1:0]};
				item_last = !tag_more && (mode_q == VM_NONE);
			end
			PH_VAL: begin
				case (mode_q)
					VM_VARINT: begin
						em_byte   = {val_more, val_q[GRP_W-1:0]};
						item_last = !val_more;
					end
					VM_LE8, VM_LE4: begin
						em_byte   = val_q[BYTE_W-1:0];
						item_last = (cnt_q == CNT_W'(1));
					end
					VM_BYTE: begin
						em_byte   = val_q[BYTE_W-1:0];
						item_last = 1'b1;
					end
					VM_ERROR: begin
						em_status = STATUS_ERR;
						item_last = 1'b1;
					end
					default: begin
						item_last = 1'b1;
					end
				endcase
			end
			default: begin
				item_last = 1'b0;
			end
		endcase
	end

	assign cmd_pop = cmd_valid && ((phase_q == PH_IDLE) || (emit && item_last));

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (cmd_pop) begin
			phase_d = cmd.has_tag ? PH_TAG : PH_VAL;
		end else if (emit && item_last) begin
			phase_d = PH_IDLE;
		end else if (emit && (phase_q == PH_TAG) && !tag_more) begin
			phase_d = PH_VAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			tag_q  <= cmd.tag;
			val_q  <= cmd.value;
			mode_q <= cmd.mode;
			cnt_q  <= (cmd.mode == VM_LE8) ? LE8_BYTES : LE4_BYTES;
		end else if (emit) begin
			if (phase_q == PH_TAG) begin
				tag_q <= tag_q >> GRP_W;
			end else if (mode_q == VM_VARINT) begin
				val_q <= val_q >> GRP_W;
			end else begin
				val_q <= val_q >> BYTE_W;
				cnt_q <= cnt_q - 1'b1;
			end
		end
		if (emit) begin
			out_byte_q <= em_byte;
			last_q     <= item_last;
			status_q   <= em_status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;
	assign status    = status_q;

	a_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_VAL) && ((mode_q == VM_LE8) || (mode_q == VM_LE4)) |-> cnt_q != '0)
		else $error("little-endian byte count ran out");

endmodule

`default_nettype wire

// File: design/protobuf_field_encoder.sv
// ----------------------------------------------------------------------------
// protobuf_field_encoder
// Protobuf wire-format field encoder: tags, varints, fixed values and raw
// payload bytes, emitted one wire byte per output transfer.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+----------------------------------------------
//   input   | in_valid / in_ready   | action, field_num, wtype, value, payload_byte
//   output  | out_valid / out_ready | out_byte, last, status
//
// The emitter produces one byte per cycle while the output is not
// stalled; an item has 1 to 15 bytes. Items that give no bytes
// (omitted zero fields) take only their input transfer.
// An item reaches the output through the queue and the emitter registers
// when the emitter is free; the front end keeps taking items into the
// command queue while the output is stalled, until the queue is full.
// Reset is asynchronous and clears the queue, the emitter phase and the
// output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module protobuf_field_encoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  action,
	input  wire logic [pfe_pkg::FNUM_W-1:0]  field_num,
	input  wire logic [pfe_pkg::WT_W-1:0]    wtype,
	input  wire logic [pfe_pkg::VAL_W-1:0]   value,
	input  wire logic [pfe_pkg::BYTE_W-1:0]  payload_byte,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [pfe_pkg::BYTE_W-1:0]       out_byte,
	output logic                             last,
	output logic                             status
);
	import pfe_pkg::*;

	// Front end to queue.
	logic      push;
	pfe_cmd_t  push_cmd;
	logic      q_full;

	// Queue to emitter.
	logic      q_valid;
	pfe_cmd_t  q_cmd;
	logic      q_pop;

	// The front end validates and classifies each item in the cycle of its
	// transfer; only items that produce bytes take a queue slot.
	pfe_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.field_num    (field_num),
		.wtype        (wtype),
		.value        (value),
		.payload_byte (payload_byte),
		.q_full       (q_full),
		.push         (push),
		.cmd          (push_cmd)
	);

	// The queue decouples input transfers from output stalls.
	pfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_cmd)
	);

	// The emitter loads the next command in the same cycle that it sends
	// the final byte of the current one, so bytes flow without gaps.
	pfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_pop   (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last),
		.status    (status)
	);

	// An error result is always a lone zero byte that closes its item.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_ERR) |-> last && (out_byte == '0))
		else $error("error result is not a final zero byte");

endmodule

`default_nettype wire
